// File: rtl/teq_pkg.sv
// Shared types and codes for the timed event queue.
package teq_pkg;

    // Request actions
    localparam logic [1:0] ACT_INSERT_ABS = 2'd0;
    localparam logic [1:0] ACT_INSERT_REL = 2'd1;
    localparam logic [1:0] ACT_CANCEL     = 2'd2;
    localparam logic [1:0] ACT_TICK       = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_INSERT    = 2'd0;
    localparam logic [1:0] KIND_CANCEL    = 2'd1;
    localparam logic [1:0] KIND_FIRED     = 2'd2;
    localparam logic [1:0] KIND_IDLE_TICK = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DISABLED  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam int TIME_W   = 48;
    localparam int CODE_W   = 16;
    localparam int HANDLE_W = 7;
    localparam int ORDER_W  = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // One slot of the event memory
    typedef struct packed {
        logic [TIME_W-1:0]  deadline;
        logic [CODE_W-1:0]  code;
        logic [ORDER_W-1:0] order;
    } slot_entry_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } teq_state_t;

endpackage

// File: rtl/timed_event_queue.sv
// Timer queue with cancel: slot memory, expiry scan and result register.
//
//   channel | signals                                  | dir | accepted when
//   --------+------------------------------------------+-----+----------------------
//   in      | action time_value event_code target_hdl  | in  | in_valid & in_ready
//   out     | kind status out_handle fired_event_code  | out | out_valid & out_ready
//           | last                                     |     |
//   cfg     | cfg_we cfg_wdata                         | in  | cfg_we
//
// Insert and cancel answer from the result register in the cycle after they are accepted.
// A tick that fires F entries runs F+1 scans of the slot memory, each
// one read per cycle through the registered read port, which sets the
// length of the tick.
// Reset clears time, counter and slot valid bits; no clearing pass.
// A full result register stalls the emit step until out_ready frees it.
module timed_event_queue #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    action,
    input  logic [teq_pkg::TIME_W-1:0]    time_value,
    input  logic [teq_pkg::CODE_W-1:0]    event_code,
    input  logic [teq_pkg::HANDLE_W-1:0]  target_handle,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic [1:0]                    status,
    output logic [teq_pkg::HANDLE_W-1:0]  out_handle,
    output logic [teq_pkg::CODE_W-1:0]    fired_event_code,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata
);
    import teq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Slot memory
    slot_entry_t mem [DEPTH];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    slot_entry_t       mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    slot_entry_t       rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Control and payload registers
    teq_state_t         state_reg, state_next;
    logic               enabled_reg, enabled_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic [ORDER_W-1:0] counter_reg, counter_next;
    logic [DEPTH-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic               chk_en_reg, chk_en_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               best_found_reg, best_found_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]  best_dl_reg, best_dl_next;
    logic [ORDER_W-1:0] best_ord_reg, best_ord_next;
    logic [CODE_W-1:0]  best_code_reg, best_code_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [CODE_W-1:0]  pend_code_reg, pend_code_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [1:0]         status_reg, status_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic               last_reg, last_next;

    // Lowest free slot
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Relative deadline with saturation
    logic [TIME_W:0]    rel_sum;
    logic [TIME_W-1:0]  ins_deadline;
    assign rel_sum      = {1'b0, time_reg} + {1'b0, time_value};
    assign ins_deadline = (action == ACT_INSERT_ABS) ? time_value :
                          (rel_sum[TIME_W] ? TIME_MAX : rel_sum[TIME_W-1:0]);

    // Cancel lookup
    logic              cancel_hit;
    logic [IDX_W-1:0]  cancel_idx;
    logic [HANDLE_W-1:0] cancel_m1;
    assign cancel_m1  = target_handle - HANDLE_W'(1);
    assign cancel_idx = cancel_m1[IDX_W-1:0];
    assign cancel_hit = (target_handle != '0) && (target_handle <= HANDLE_W'(DEPTH))
                        && valid_reg[cancel_idx];

    // Candidate from the scan read
    logic [ORDER_W-1:0] ord_diff;
    logic               cand_due, cand_better;
    assign ord_diff    = rd_data_reg.order - best_ord_reg;
    assign cand_due    = chk_en_reg && valid_reg[chk_idx_reg]
                         && (rd_data_reg.deadline <= time_reg);
    assign cand_better = !best_found_reg || (rd_data_reg.deadline < best_dl_reg)
                         || ((rd_data_reg.deadline == best_dl_reg) && ord_diff[ORDER_W-1]);

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        enabled_next    = cfg_we ? cfg_wdata : enabled_reg;
        time_next       = time_reg;
        counter_next    = counter_reg;
        valid_next      = valid_reg;
        scan_cnt_next   = scan_cnt_reg;
        chk_en_next     = 1'b0;
        chk_idx_next    = chk_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_dl_next    = best_dl_reg;
        best_ord_next   = best_ord_reg;
        best_code_next  = best_code_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_code_next  = pend_code_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        status_next     = status_reg;
        handle_next     = handle_reg;
        code_next       = code_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_idx;
        mem_wdata       = '{deadline: ins_deadline, code: event_code, order: counter_reg};
        mem_re          = 1'b0;
        mem_raddr       = scan_cnt_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (action)
                        ACT_INSERT_ABS, ACT_INSERT_REL:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_INSERT;
                            code_next      = '0;
                            last_next      = 1'b1;
                            handle_next    = '0;
                            if (!enabled_reg)
                            begin
                                status_next = ST_DISABLED;
                            end
                            else if (!free_found)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next          = ST_OK;
                                handle_next          = HANDLE_W'(free_idx) + HANDLE_W'(1);
                                valid_next[free_idx] = 1'b1;
                                mem_we               = 1'b1;
                                counter_next         = counter_reg + ORDER_W'(1);
                            end
                        end
                        ACT_CANCEL:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_CANCEL;
                            code_next      = '0;
                            last_next      = 1'b1;
                            if (cancel_hit)
                            begin
                                status_next            = ST_OK;
                                handle_next            = target_handle;
                                valid_next[cancel_idx] = 1'b0;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                                handle_next = '0;
                            end
                        end
                        default:
                        begin
                            time_next       = time_reg + TIME_W'(1);
                            state_next      = S_SCAN;
                            scan_cnt_next   = '0;
                            best_found_next = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle, compare the one returned
                if (scan_cnt_reg < CNT_W'(DEPTH))
                begin
                    mem_re        = 1'b1;
                    chk_en_next   = 1'b1;
                    chk_idx_next  = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_EMIT;
                end
                if (cand_due && cand_better)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = chk_idx_reg;
                    best_dl_next    = rd_data_reg.deadline;
                    best_ord_next   = rd_data_reg.order;
                    best_code_next  = rd_data_reg.code;
                end
            end

            S_EMIT:
            begin
                // held entry goes out once we know whether another follows
                if (best_found_reg)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_FIRED;
                            status_next    = ST_OK;
                            handle_next    = HANDLE_W'(pend_idx_reg) + HANDLE_W'(1);
                            code_next      = pend_code_reg;
                            last_next      = 1'b0;
                        end
                        pend_valid_next          = 1'b1;
                        pend_idx_next            = best_idx_reg;
                        pend_code_next           = best_code_reg;
                        valid_next[best_idx_reg] = 1'b0;
                        best_found_next          = 1'b0;
                        scan_cnt_next            = '0;
                        state_next               = S_SCAN;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    last_next      = 1'b1;
                    if (pend_valid_reg)
                    begin
                        kind_next   = KIND_FIRED;
                        handle_next = HANDLE_W'(pend_idx_reg) + HANDLE_W'(1);
                        code_next   = pend_code_reg;
                    end
                    else
                    begin
                        kind_next   = KIND_IDLE_TICK;
                        handle_next = '0;
                        code_next   = '0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            enabled_reg    <= 1'b1;
            time_reg       <= '0;
            counter_reg    <= '0;
            valid_reg      <= '0;
            scan_cnt_reg   <= '0;
            chk_en_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            enabled_reg    <= enabled_next;
            time_reg       <= time_next;
            counter_reg    <= counter_next;
            valid_reg      <= valid_next;
            scan_cnt_reg   <= scan_cnt_next;
            chk_en_reg     <= chk_en_next;
            best_found_reg <= best_found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        best_idx_reg  <= best_idx_next;
        best_dl_reg   <= best_dl_next;
        best_ord_reg  <= best_ord_next;
        best_code_reg <= best_code_next;
        pend_idx_reg  <= pend_idx_next;
        pend_code_reg <= pend_code_next;
        kind_reg      <= kind_next;
        status_reg    <= status_next;
        handle_reg    <= handle_next;
        code_reg      <= code_next;
        last_reg      <= last_next;
    end

    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign status           = status_reg;
    assign out_handle       = handle_reg;
    assign fired_event_code = code_reg;
    assign last             = last_reg;

endmodule

// File: rtl/teq_checker.sv
// Port-level checks for the timed event queue, bound to the top level.
module teq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    kind,
    input logic [1:0]                    status,
    input logic [teq_pkg::HANDLE_W-1:0]  out_handle,
    input logic [teq_pkg::CODE_W-1:0]    fired_event_code,
    input logic                          last
);
    import teq_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_handle)
        && $stable(fired_event_code) && $stable(last))
        else $error("result changed while stalled");

    // insert, cancel and idle-tick answers are single
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_INSERT || kind == KIND_CANCEL || kind == KIND_IDLE_TICK)
        |-> last)
        else $error("single answer without last");

    // fired entries always carry a real handle
    a_fired: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_FIRED |-> status == ST_OK && out_handle != '0)
        else $error("bad fired result");

    // failures carry no handle
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> out_handle == '0 && fired_event_code == '0)
        else $error("failed request with handle");

endmodule

bind timed_event_queue teq_checker u_teq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .status           (status),
    .out_handle       (out_handle),
    .fired_event_code (fired_event_code),
    .last             (last)
);
